[sv/fpcc_pkg.sv]
// ----------------------------------------------------------------------------
// fpcc_pkg
// Shared widths, status codes, the frame snapshot type and the CRC-16/MODBUS
// byte update used by the framed packet CRC checker.
// ----------------------------------------------------------------------------
package fpcc_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int COUNT_W  = 17;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int DELAY_DEPTH = 4;

  localparam logic [COUNT_W-1:0] MIN_FRAME = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [WORD_W-1:0]  CRC_INIT  = 16'hFFFF;
  localparam logic [WORD_W-1:0]  CRC_POLY  = 16'hA001;

  // Status codes of a verdict.
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HEAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAIL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LEN   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CRC   = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_WORD = 2'd1;

  // Everything the verdict needs, taken when the last byte of a frame arrives.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  head_seen;
    logic [WORD_W-1:0]  length_field;
    logic [WORD_W-1:0]  crc;
    logic [WORD_W-1:0]  rx_crc;
    logic [WORD_W-1:0]  rx_tail;
  } snap_t;

  // One byte of reflected CRC-16 (polynomial 0xA001), bit by bit.
  function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/fpcc_byte_if.sv]
// ----------------------------------------------------------------------------
// fpcc_byte_if
// Frame byte channel: one byte per request, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface fpcc_byte_if;
  import fpcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

[sv/fpcc_result_if.sv]
// ----------------------------------------------------------------------------
// fpcc_result_if
// Verdict channel: one status code and the received frame length per request.
// ----------------------------------------------------------------------------
interface fpcc_result_if;
  import fpcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  frame_length;

  modport source (output valid, output status, output frame_length, input ready);
  modport sink   (input valid, input status, input frame_length, output ready);
endinterface

[sv/fpcc_cfg_if.sv]
// ----------------------------------------------------------------------------
// fpcc_cfg_if
// Configuration write channel: register index and write data per request.
// ----------------------------------------------------------------------------
interface fpcc_cfg_if;
  import fpcc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/fpcc_tracker.sv]
// ----------------------------------------------------------------------------
// fpcc_tracker
// Per-byte frame state: byte counter, head and length capture, delay line
// and running body CRC. On the final byte it registers a snapshot for the
// verdict stage and clears the frame state.
// ----------------------------------------------------------------------------
module fpcc_tracker (
  input  logic                clk,
  input  logic                rst,
  fpcc_byte_if.sink           byte_in,
  output logic                snap_valid,
  input  logic                snap_ready,
  output fpcc_pkg::snap_t     snap
);
  import fpcc_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [WORD_W-1:0]  crc_register;
  logic [BYTE_W-1:0]  delay_line [DELAY_DEPTH];
  logic [WORD_W-1:0]  head_seen;
  logic [WORD_W-1:0]  length_field;

  logic [COUNT_W-1:0] byte_count_next;
  logic [WORD_W-1:0]  crc_register_next;
  logic [BYTE_W-1:0]  delay_line_next [DELAY_DEPTH];
  logic [WORD_W-1:0]  head_seen_next;
  logic [WORD_W-1:0]  length_field_next;
  logic               accept;

  // The snapshot slot frees up in the same cycle the verdict stage takes it.
  assign byte_in.ready = !snap_valid || snap_ready;
  assign accept = byte_in.valid && byte_in.ready;

  always_comb begin
    head_seen_next    = head_seen;
    length_field_next = length_field;
    if (byte_count == COUNT_W'(0)) begin
      head_seen_next[15:8] = byte_in.data_byte;
    end else if (byte_count == COUNT_W'(1)) begin
      head_seen_next[7:0] = byte_in.data_byte;
    end else if (byte_count == COUNT_W'(2)) begin
      length_field_next[15:8] = byte_in.data_byte;
    end else if (byte_count == COUNT_W'(3)) begin
      length_field_next[7:0] = byte_in.data_byte;
    end

    // Bytes leaving the delay line once the byte count reaches eight are body bytes, so
    // the trailing CRC and tail never reach the CRC register.
    if (byte_count >= MIN_FRAME) begin
      crc_register_next = crc_feed(crc_register, delay_line[0]);
    end else begin
      crc_register_next = crc_register;
    end

    for (int i = 0; i < DELAY_DEPTH - 1; i++) begin
      delay_line_next[i] = delay_line[i+1];
    end
    delay_line_next[DELAY_DEPTH-1] = byte_in.data_byte;

    if (byte_count != COUNT_MAX) begin
      byte_count_next = byte_count + COUNT_W'(1);
    end else begin
      byte_count_next = byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      crc_register <= CRC_INIT;
      head_seen    <= '0;
      length_field <= '0;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        delay_line[i] <= '0;
      end
    end else if (accept) begin
      if (byte_in.last) begin
        byte_count   <= '0;
        crc_register <= CRC_INIT;
        head_seen    <= '0;
        length_field <= '0;
        for (int i = 0; i < DELAY_DEPTH; i++) begin
          delay_line[i] <= '0;
        end
      end else begin
        byte_count   <= byte_count_next;
        crc_register <= crc_register_next;
        head_seen    <= head_seen_next;
        length_field <= length_field_next;
        for (int i = 0; i < DELAY_DEPTH; i++) begin
          delay_line[i] <= delay_line_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && byte_in.last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_in.last) begin
      snap.count        <= byte_count_next;
      snap.head_seen    <= head_seen_next;
      snap.length_field <= length_field_next;
      snap.crc          <= crc_register_next;
      snap.rx_crc       <= {delay_line_next[0], delay_line_next[1]};
      snap.rx_tail      <= {delay_line_next[2], delay_line_next[3]};
    end
  end

endmodule

[sv/fpcc_verdict.sv]
// ----------------------------------------------------------------------------
// fpcc_verdict
// Runs the ordered frame checks on a snapshot and holds the result in the
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module fpcc_verdict (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          head_word,
  input  logic [15:0]          tail_word,
  input  logic                 snap_valid,
  output logic                 snap_ready,
  input  fpcc_pkg::snap_t      snap,
  fpcc_result_if.source        result_out
);
  import fpcc_pkg::*;

  logic                res_valid;
  logic [STATUS_W-1:0] status_next;
  logic [COUNT_W-1:0]  expected_count;

  assign snap_ready = !res_valid || result_out.ready;
  assign result_out.valid = res_valid;
  assign expected_count = {1'b0, snap.length_field} + MIN_FRAME;

  // The first failing check decides the status.
  always_comb begin
    if (snap.count <= MIN_FRAME) begin
      status_next = ST_SHORT;
    end else if (snap.head_seen != head_word) begin
      status_next = ST_HEAD;
    end else if (snap.rx_tail != tail_word) begin
      status_next = ST_TAIL;
    end else if (snap.count != expected_count) begin
      status_next = ST_LEN;
    end else if (snap.crc != snap.rx_crc) begin
      status_next = ST_CRC;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (snap_ready) begin
      res_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      result_out.status       <= status_next;
      result_out.frame_length <= snap.count;
    end
  end

endmodule

[sv/framed_packet_crc_checker.sv]
// ----------------------------------------------------------------------------
// framed_packet_crc_checker
// Checks head, tail, length and body CRC-16/MODBUS of byte-serial frames.
// A verdict passes through the snapshot register and then the result register.
// Throughput: one byte per cycle while the snapshot slot is free; the CRC updates a whole byte per cycle.
// Reset: synchronous; clears frame state, pipeline valids and both
// configuration registers (head and tail words read as zero).
// ----------------------------------------------------------------------------
module framed_packet_crc_checker (
  input  logic          clk,
  input  logic          rst,
  fpcc_cfg_if.sink      cfg,
  fpcc_byte_if.sink     byte_in,
  fpcc_result_if.source result_out
);
  import fpcc_pkg::*;

  logic [WORD_W-1:0] head_word;
  logic [WORD_W-1:0] tail_word;
  logic              snap_valid;
  logic              snap_ready;
  snap_t             snap;

  assign cfg.ready = 1'b1;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_word <= '0;
      tail_word <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEAD_WORD: head_word <= cfg.data;
        REG_TAIL_WORD: tail_word <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  fpcc_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  fpcc_verdict u_verdict (
    .clk        (clk),
    .rst        (rst),
    .head_word  (head_word),
    .tail_word  (tail_word),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .result_out (result_out)
  );

endmodule
